// File: design/assert_macros.svh
// Assertion macros used by the top-level design file.
// Expects signals named clk and rst in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RTH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RTH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rth_pkg.sv
// Types and fixed constants for the RGB to HSV converter.
// No dependencies.
package rth_pkg;

  localparam int FIELD_BITS  = 8;
  localparam int HUE_BITS    = 15;
  localparam int HUE_DEGREES = 360;
  // 60 = 64 - 4
  localparam int HUE_MUL_SHIFT = 6;
  localparam int HUE_SUB_SHIFT = 2;

  typedef struct packed {
    logic [FIELD_BITS-1:0] red;
    logic [FIELD_BITS-1:0] green;
    logic [FIELD_BITS-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]   hue;
    logic [FIELD_BITS-1:0] saturation;
    logic [FIELD_BITS-1:0] brightness;
    logic                  hue_undefined;
  } hsv_t;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

endpackage

// File: design/rth_stream_if.sv
// Valid/ready stream channel carrying one word of payload_t.
// Used with the rth_pkg payload types.
interface rth_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/rth_front.sv
// Front end: max/min and sector, delta and hue numerator, divider operands.
// Three register stages; depends on rth_pkg.
module rth_front #(
  parameter int CHANNEL_BITS      = 8,
  parameter int HUE_FRACTION_BITS = 6,
  parameter int HUE_Q_BITS        = 15
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [CHANNEL_BITS-1:0]            red,
  input  logic [CHANNEL_BITS-1:0]            green,
  input  logic [CHANNEL_BITS-1:0]            blue,
  output logic [CHANNEL_BITS+HUE_Q_BITS-1:0] hue_num,
  output logic [2*CHANNEL_BITS-1:0]          sat_num,
  output logic [CHANNEL_BITS-1:0]            delta,
  output logic [CHANNEL_BITS-1:0]            maximum,
  output logic                               undefined
);
  import rth_pkg::*;

  localparam int NUM_BITS = CHANNEL_BITS + 3;
  localparam int HNW      = CHANNEL_BITS + HUE_Q_BITS;
  localparam int SNW      = 2 * CHANNEL_BITS;

  // stage 1
  logic [CHANNEL_BITS-1:0] r1, g1, b1, mx1, mn1;
  sector_t                 sec1;
  sector_t                 sec;
  logic [CHANNEL_BITS-1:0] mx, mn;

  always_comb begin
    if (red >= green && red >= blue) begin
      sec = SEC_RED;
    end else if (green >= blue) begin
      sec = SEC_GREEN;
    end else begin
      sec = SEC_BLUE;
    end
    case (sec)
      SEC_RED:   mx = red;
      SEC_GREEN: mx = green;
      default:   mx = blue;
    endcase
    mn = red;
    if (green < mn) begin
      mn = green;
    end
    if (blue < mn) begin
      mn = blue;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1   <= red;
      g1   <= green;
      b1   <= blue;
      mx1  <= mx;
      mn1  <= mn;
      sec1 <= sec;
    end
  end

  // stage 2: numerator in units of delta, sector offset folded in
  logic [CHANNEL_BITS-1:0] mx2, delta2, d;
  logic [NUM_BITS-1:0]     num2, num, dw, rw, gw, bw;
  logic                    undef2;

  always_comb begin
    d  = mx1 - mn1;
    dw = NUM_BITS'(d);
    rw = NUM_BITS'(r1);
    gw = NUM_BITS'(g1);
    bw = NUM_BITS'(b1);
    case (sec1)
      SEC_RED: begin
        if (g1 >= b1) begin
          num = gw - bw;
        end else begin
          num = (dw << 2) + (dw << 1) + gw - bw;
        end
      end
      SEC_GREEN: num = (dw << 1) + bw - rw;
      SEC_BLUE:  num = (dw << 2) + rw - gw;
      default:   num = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx2    <= mx1;
      delta2 <= d;
      num2   <= num;
      undef2 <= (d == '0);
    end
  end

  // stage 3: divider numerators
  always_ff @(posedge clk) begin
    if (en) begin
      hue_num   <= (HNW'(num2) << (HUE_MUL_SHIFT + HUE_FRACTION_BITS))
                 - (HNW'(num2) << (HUE_SUB_SHIFT + HUE_FRACTION_BITS));
      sat_num   <= (SNW'(delta2) << CHANNEL_BITS) - SNW'(delta2);
      delta     <= delta2;
      maximum   <= mx2;
      undefined <= undef2;
    end
  end

endmodule

// File: design/rth_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit QUO_BITS; stages past QUO_BITS only carry the word.
module rth_div #(
  parameter int DEN_BITS = 8,
  parameter int QUO_BITS = 8,
  parameter int STAGES   = 8
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [DEN_BITS+QUO_BITS-1:0] num,
  input  logic [DEN_BITS-1:0]          den,
  output logic [QUO_BITS-1:0]          quo
);
  localparam int WORK_BITS = DEN_BITS + QUO_BITS;

  // {partial remainder, numerator bits left / quotient bits so far}
  logic [WORK_BITS-1:0] work [STAGES];
  logic [DEN_BITS-1:0]  dvs  [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [WORK_BITS-1:0] w_in, w_next;
    logic [DEN_BITS-1:0]  d_in;

    if (k == 0) begin : g_first
      assign w_in = num;
      assign d_in = den;
    end else begin : g_rest
      assign w_in = work[k-1];
      assign d_in = dvs[k-1];
    end

    if (k < QUO_BITS) begin : g_step
      logic [DEN_BITS:0]   trial;
      logic [DEN_BITS-1:0] rem;
      logic                qbit;
      always_comb begin
        trial = w_in[WORK_BITS-1 -: DEN_BITS+1];
        qbit  = (trial >= {1'b0, d_in});
        rem   = qbit ? DEN_BITS'(trial - {1'b0, d_in}) : DEN_BITS'(trial);
        w_next = {rem, w_in[QUO_BITS-1:0] << 1} | WORK_BITS'(qbit);
      end
    end else begin : g_hold
      assign w_next = w_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        work[k] <= w_next;
        dvs[k]  <= d_in;
      end
    end
  end

  assign quo = work[STAGES-1][QUO_BITS-1:0];

endmodule

// File: design/rgb_to_hsv_converter.sv
// Top level: RGB pixel in, hue/saturation/value out, fully pipelined.
// Depends on rth_pkg, rth_stream_if, rth_front, rth_div, assert_macros.svh.
//
//   channel | dir | payload                                   | handshake
//   rgb     | in  | red, green, blue                          | valid/ready
//   hsv     | out | hue, saturation, brightness, hue_undefined | valid/ready
//
// One pixel per cycle sustained while the sink does not stall; each pixel
// passes through the front stages and then the bit-per-stage dividers.
// Reset clears the stage valid bits and the skid full flag only.
// When the sink stalls, the skid register takes one word and the whole pipe
// then holds; rgb.ready is a flop output.
module rgb_to_hsv_converter #(
  parameter int CHANNEL_BITS      = 8,
  parameter int HUE_FRACTION_BITS = 6
) (
  input  logic              clk,
  input  logic              rst,
  rth_stream_if.sink        rgb,
  rth_stream_if.source      hsv
);
  import rth_pkg::*;
  `include "assert_macros.svh"

  localparam int HUE_LIMIT  = HUE_DEGREES * (2 ** HUE_FRACTION_BITS);
  localparam int HUE_Q_BITS = $clog2(HUE_LIMIT);
  localparam int DIV_STAGES = (HUE_Q_BITS > CHANNEL_BITS) ? HUE_Q_BITS : CHANNEL_BITS;
  localparam int NSTAGE     = 3 + DIV_STAGES;

  logic                               en;
  logic                               skid_full;
  hsv_t                               skid, out_now;
  logic [NSTAGE-1:0]                  v;
  logic [CHANNEL_BITS-1:0]            red, green, blue;
  logic [CHANNEL_BITS+HUE_Q_BITS-1:0] hue_num;
  logic [2*CHANNEL_BITS-1:0]          sat_num;
  logic [CHANNEL_BITS-1:0]            delta, maximum;
  logic                               undefined;
  logic [HUE_Q_BITS-1:0]              hue_q;
  logic [CHANNEL_BITS-1:0]            sat_q;
  logic [CHANNEL_BITS-1:0]            mx_p [DIV_STAGES];
  logic                               un_p [DIV_STAGES];

  assign en        = !skid_full;
  assign rgb.ready = en;

  assign red   = CHANNEL_BITS'(rgb.data.red);
  assign green = CHANNEL_BITS'(rgb.data.green);
  assign blue  = CHANNEL_BITS'(rgb.data.blue);

  rth_front #(
    .CHANNEL_BITS      (CHANNEL_BITS),
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
    .HUE_Q_BITS        (HUE_Q_BITS)
  ) u_front (
    .clk       (clk),
    .en        (en),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .hue_num   (hue_num),
    .sat_num   (sat_num),
    .delta     (delta),
    .maximum   (maximum),
    .undefined (undefined)
  );

  rth_div #(
    .DEN_BITS (CHANNEL_BITS),
    .QUO_BITS (HUE_Q_BITS),
    .STAGES   (DIV_STAGES)
  ) u_hue_div (
    .clk (clk),
    .en  (en),
    .num (hue_num),
    .den (delta),
    .quo (hue_q)
  );

  rth_div #(
    .DEN_BITS (CHANNEL_BITS),
    .QUO_BITS (CHANNEL_BITS),
    .STAGES   (DIV_STAGES)
  ) u_sat_div (
    .clk (clk),
    .en  (en),
    .num (sat_num),
    .den (maximum),
    .quo (sat_q)
  );

  // side band alongside the dividers
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_side
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          mx_p[k] <= maximum;
          un_p[k] <= undefined;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en) begin
          mx_p[k] <= mx_p[k-1];
          un_p[k] <= un_p[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NSTAGE-2:0], rgb.valid};
    end
  end

  always_comb begin
    out_now.hue           = un_p[DIV_STAGES-1] ? '0 : HUE_BITS'(hue_q);
    out_now.saturation    = un_p[DIV_STAGES-1] ? '0 : FIELD_BITS'(sat_q);
    out_now.brightness    = FIELD_BITS'(mx_p[DIV_STAGES-1]);
    out_now.hue_undefined = un_p[DIV_STAGES-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      skid_full <= !hsv.ready;
    end else begin
      skid_full <= v[NSTAGE-1] && !hsv.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skid <= out_now;
    end
  end

  assign hsv.valid = skid_full || v[NSTAGE-1];
  assign hsv.data  = skid_full ? skid : out_now;

  `RTH_ASSERT_IMPL(a_hue_range, v[NSTAGE-1] && !un_p[DIV_STAGES-1],
                   32'(hue_q) < HUE_LIMIT, "hue quotient out of range")
  `RTH_ASSERT_IMPL(a_sat_nonzero, v[NSTAGE-1] && !un_p[DIV_STAGES-1],
                   sat_q != '0, "coloured pixel with zero saturation")
  `RTH_ASSERT_IMPL(a_black_undef, v[NSTAGE-1] && mx_p[DIV_STAGES-1] == '0,
                   un_p[DIV_STAGES-1], "black pixel not flagged undefined")
  `RTH_ASSERT_NEXT(a_skid_catch, v[NSTAGE-1] && !skid_full && !hsv.ready,
                   skid_full, "stalled word not caught by skid")

endmodule
